// File: sv/kettq_pkg.sv
package kettq_pkg;

  // input action codes
  localparam logic [2:0] ACT_PRESS   = 3'd0;
  localparam logic [2:0] ACT_RELEASE = 3'd1;
  localparam logic [2:0] ACT_POLL    = 3'd2;
  localparam logic [2:0] ACT_QUERY   = 3'd3;
  localparam logic [2:0] ACT_FLUSH   = 3'd4;

  localparam int unsigned KEY_W      = 16;
  localparam int unsigned INDEX_W    = 7;
  localparam int unsigned POLL_W     = 17;
  localparam logic [POLL_W-1:0] POLL_EMPTY = 17'h1FFFF;

  // nonzero values up to this one set a held bit but are never queued
  localparam logic [KEY_W-1:0] QUEUE_MIN_EXCL = 16'd4;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_PRESS,
    OP_RELEASE,
    OP_POLL,
    OP_QUERY,
    OP_FLUSH,
    OP_NONE
  } kettq_op_t;

  typedef struct packed {
    kettq_op_t          op;
    logic [KEY_W-1:0]   value;
    logic [INDEX_W-1:0] key_index;
  } kettq_entry_t;

  typedef enum logic {
    BS_IDLE,
    BS_POLL
  } kettq_bstate_t;

endpackage

// File: sv/kettq_front.sv
module kettq_front import kettq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_action,
  input  logic [7:0]         in_key_code,
  input  logic [15:0]        in_char_code,
  input  logic [6:0]         in_key_index,
  output logic               push_valid,
  input  logic               push_ready,
  output kettq_entry_t       push_entry
);

  localparam logic [7:0] KC_BACKSPACE = 8'd8;
  localparam logic [7:0] KC_TAB       = 8'd9;
  localparam logic [7:0] KC_LF        = 8'd10;
  localparam logic [7:0] KC_ENTER     = 8'd13;
  localparam logic [7:0] KC_SHIFT     = 8'd16;
  localparam logic [7:0] KC_CTRL      = 8'd17;
  localparam logic [7:0] KC_ALT       = 8'd18;
  localparam logic [7:0] KC_PGUP      = 8'd33;
  localparam logic [7:0] KC_PGDN      = 8'd34;
  localparam logic [7:0] KC_END       = 8'd35;
  localparam logic [7:0] KC_HOME      = 8'd36;
  localparam logic [7:0] KC_LEFT      = 8'd37;
  localparam logic [7:0] KC_UP        = 8'd38;
  localparam logic [7:0] KC_RIGHT     = 8'd39;
  localparam logic [7:0] KC_DOWN      = 8'd40;
  localparam logic [7:0] KC_DELETE    = 8'd127;
  localparam logic [7:0] KC_F1        = 8'd112;
  localparam logic [7:0] KC_F12       = 8'd123;
  localparam logic [15:0] CHAR_MIN    = 16'd30;
  localparam logic [15:0] FKEY_BASE   = 16'd1008;

  logic             fkey_en_r;
  logic             fkey_en_nxt;
  logic [KEY_W-1:0] tk;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fkey_en_r <= 1'b0;
    end else begin
      fkey_en_r <= fkey_en_nxt;
    end
  end

  assign fkey_en_nxt = cfg_wr_en ? cfg_wr_data : fkey_en_r;

  always_comb begin
    tk = (in_char_code < CHAR_MIN) ? '0 : in_char_code;
    case (in_key_code) inside
      KC_LEFT:             tk = 16'd1;
      KC_RIGHT:            tk = 16'd2;
      KC_UP:               tk = 16'd3;
      KC_DOWN:             tk = 16'd4;
      KC_CTRL:             tk = 16'd5;
      KC_SHIFT:            tk = 16'd6;
      KC_ALT:              tk = 16'd7;
      KC_BACKSPACE,
      KC_DELETE:           tk = 16'd8;
      KC_TAB:              tk = 16'd9;
      KC_LF:               tk = 16'd10;
      KC_ENTER:            tk = 16'd13;
      KC_HOME:             tk = 16'd1000;
      KC_END:              tk = 16'd1001;
      KC_PGUP:             tk = 16'd1002;
      KC_PGDN:             tk = 16'd1003;
      [KC_F1:KC_F12]: begin
        if (fkey_en_r) begin
          tk = FKEY_BASE + {8'd0, in_key_code - KC_F1};
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    push_entry.key_index = in_key_index;
    push_entry.value     = '0;
    case (in_action)
      ACT_PRESS: begin
        push_entry.op    = OP_PRESS;
        push_entry.value = tk;
      end
      ACT_RELEASE: begin
        push_entry.op    = OP_RELEASE;
        push_entry.value = tk;
      end
      ACT_POLL:  push_entry.op = OP_POLL;
      ACT_QUERY: push_entry.op = OP_QUERY;
      ACT_FLUSH: push_entry.op = OP_FLUSH;
      default:   push_entry.op = OP_NONE;
    endcase
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

// File: sv/kettq_queue.sv
module kettq_queue import kettq_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  kettq_entry_t push_entry,
  output logic         pop_valid,
  input  logic         pop,
  output kettq_entry_t pop_entry
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  kettq_entry_t  slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count_r != CW'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: sv/kettq_back.sv
module kettq_back import kettq_pkg::*; #(
  parameter int RING_DEPTH     = 128,
  parameter int HELD_KEY_COUNT = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_pop,
  input  kettq_entry_t        q_entry,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [KEY_W-1:0]    out_translated_key,
  output logic signed [POLL_W-1:0] out_polled_key,
  output logic                out_held
);

  localparam int unsigned RW = $clog2(RING_DEPTH);
  localparam int unsigned HW = $clog2(HELD_KEY_COUNT);
  localparam int unsigned IW = (HW > INDEX_W) ? HW : INDEX_W;

  kettq_bstate_t state_r, state_nxt;

  logic [HELD_KEY_COUNT-1:0] held_r, held_nxt;
  logic [RW-1:0]     wp_r, wp_nxt;
  logic [RW-1:0]     rp_r, rp_nxt;
  logic [RW-1:0]     wp_inc, rp_inc;

  logic [KEY_W-1:0]  ring_mem [RING_DEPTH];
  logic [KEY_W-1:0]  rd_data_r;
  logic              ring_we;
  logic              ring_re;

  logic              out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]  tk_r;
  logic [POLL_W-1:0] polled_r;
  logic              held_bit_r;

  logic              out_load;
  logic [KEY_W-1:0]  tk_load;
  logic [POLL_W-1:0] polled_load;
  logic              held_load;
  logic              slot_free;
  logic              tk_in_range;
  logic              idx_in_range;
  logic [IW-1:0]     idx_ext;

  assign slot_free    = !out_valid_r || out_ready;
  assign wp_inc       = (wp_r == RW'(RING_DEPTH - 1)) ? '0 : wp_r + RW'(1);
  assign rp_inc       = (rp_r == RW'(RING_DEPTH - 1)) ? '0 : rp_r + RW'(1);
  assign tk_in_range  = (q_entry.value != '0) &&
                        ({16'd0, q_entry.value} < 32'(HELD_KEY_COUNT));
  assign idx_ext      = IW'(q_entry.key_index);
  assign idx_in_range = ({25'd0, q_entry.key_index} < 32'(HELD_KEY_COUNT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      held_r      <= '0;
      wp_r        <= '0;
      rp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    held_nxt    = held_r;
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    q_pop       = 1'b0;
    ring_we     = 1'b0;
    ring_re     = 1'b0;
    out_load    = 1'b0;
    tk_load     = '0;
    polled_load = POLL_EMPTY;
    held_load   = 1'b0;
    case (state_r)
      BS_IDLE: begin
        if (q_valid && slot_free) begin
          q_pop = 1'b1;
          case (q_entry.op)
            OP_PRESS: begin
              out_load = 1'b1;
              tk_load  = q_entry.value;
              if (tk_in_range) begin
                held_nxt[q_entry.value[HW-1:0]] = 1'b1;
              end
              if (q_entry.value > QUEUE_MIN_EXCL) begin
                ring_we = 1'b1;
                wp_nxt  = wp_inc;
              end
            end
            OP_RELEASE: begin
              out_load = 1'b1;
              tk_load  = q_entry.value;
              if (tk_in_range) begin
                held_nxt[q_entry.value[HW-1:0]] = 1'b0;
              end
            end
            OP_POLL: begin
              if (rp_r != wp_r) begin
                // ring data comes back registered; answer from BS_POLL
                ring_re   = 1'b1;
                rp_nxt    = rp_inc;
                state_nxt = BS_POLL;
              end else begin
                out_load = 1'b1;
              end
            end
            OP_QUERY: begin
              out_load  = 1'b1;
              held_load = idx_in_range && held_r[idx_ext[HW-1:0]];
            end
            OP_FLUSH: begin
              out_load = 1'b1;
              rp_nxt   = wp_r;
            end
            default: out_load = 1'b1;
          endcase
        end
      end
      BS_POLL: begin
        if (slot_free) begin
          out_load    = 1'b1;
          polled_load = {1'b0, rd_data_r};
          state_nxt   = BS_IDLE;
        end
      end
      default: state_nxt = BS_IDLE;
    endcase
    out_valid_nxt = out_load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[wp_r] <= q_entry.value;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_re) begin
      rd_data_r <= ring_mem[rp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      tk_r       <= tk_load;
      polled_r   <= polled_load;
      held_bit_r <= held_load;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_translated_key = tk_r;
  assign out_polled_key     = $signed(polled_r);
  assign out_held           = held_bit_r;

`ifndef NO_ASSERTIONS
  a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    !(ring_we && ring_re))
    else $error("ring read and write in the same cycle");

  a_push_moves_wp: assert property (@(posedge clk) disable iff (!rst_n)
    ring_we |=> (wp_r != $past(wp_r)))
    else $error("push did not advance write pointer");

  a_poll_enters_wait: assert property (@(posedge clk) disable iff (!rst_n)
    ring_re |=> (state_r == BS_POLL) && (rp_r != $past(rp_r)))
    else $error("poll read not followed by wait state");

  a_poll_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BS_POLL) && slot_free |=>
      out_valid_r && (tk_r == '0) && !polled_r[POLL_W-1] && !held_bit_r)
    else $error("poll result malformed");

  a_no_pop_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BS_POLL) |-> !q_pop)
    else $error("item taken while poll pending");
`endif

endmodule

// File: sv/key_event_translate_queue_core.sv
// Keyboard event translator with held-key bitmap and a key ring. Each item
// (press, release, poll, query, flush) gives exactly one result. The front
// translates and classifies an item in the cycle it is accepted and drops it
// into a two-entry queue; the back executes it and registers the result, so
// out_valid rises only once the item has passed the queue slot and the output
// register. The back finishes one item per cycle while out_ready allows, but a
// poll that finds the ring non-empty waits in BS_POLL for the registered ring
// memory read. Reset clears the held-key bitmap but not the ring contents;
// with no full check, RING_DEPTH unread pushes make the ring look empty.
module key_event_translate_queue_core import kettq_pkg::*; #(
  parameter int RING_DEPTH     = 128,
  parameter int HELD_KEY_COUNT = 128
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic                     cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               in_action,
  input  logic [7:0]               in_key_code,
  input  logic [15:0]              in_char_code,
  input  logic [6:0]               in_key_index,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [15:0]              out_translated_key,
  output logic signed [16:0]       out_polled_key,
  output logic                     out_held
);

  logic         push_valid;
  logic         push_ready;
  kettq_entry_t push_entry;
  logic         q_valid;
  logic         q_pop;
  kettq_entry_t q_entry;

  kettq_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_key_code  (in_key_code),
    .in_char_code (in_char_code),
    .in_key_index (in_key_index),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_entry   (push_entry)
  );

  kettq_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_entry  (q_entry)
  );

  kettq_back #(
    .RING_DEPTH     (RING_DEPTH),
    .HELD_KEY_COUNT (HELD_KEY_COUNT)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_pop              (q_pop),
    .q_entry            (q_entry),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_translated_key (out_translated_key),
    .out_polled_key     (out_polled_key),
    .out_held           (out_held)
  );

endmodule

// File: tb/tb_key_event_translate_queue_core.sv
import kettq_pkg::*;

localparam int HELD_KEY_SLOTS = 128;
localparam int RING_SLOTS     = 128;

typedef struct packed {
  logic [15:0] tkey;
  logic [16:0] polled;
  logic        held;
} key_result_t;

class key_scoreboard;
  bit          fkey_map_en;
  bit          held_map [HELD_KEY_SLOTS];
  bit [15:0]   ring [RING_SLOTS];
  bit [6:0]    rd_ptr;
  bit [6:0]    wr_ptr;
  key_result_t expected_q [$];
  int          mismatches;

  function int pending();
    return expected_q.size();
  endfunction

  function logic [15:0] translate_key(logic [7:0] code, logic [15:0] ch);
    logic [15:0] v;
    v = (ch < 16'd30) ? 16'd0 : ch;
    case (code)
      8'd37: v = 16'd1;
      8'd39: v = 16'd2;
      8'd38: v = 16'd3;
      8'd40: v = 16'd4;
      8'd17: v = 16'd5;
      8'd16: v = 16'd6;
      8'd18: v = 16'd7;
      8'd8, 8'd127: v = 16'd8;
      8'd9:  v = 16'd9;
      8'd10: v = 16'd10;
      8'd13: v = 16'd13;
      8'd36: v = 16'd1000;
      8'd35: v = 16'd1001;
      8'd33: v = 16'd1002;
      8'd34: v = 16'd1003;
      default: begin
        if (fkey_map_en && code >= 8'd112 && code <= 8'd123)
          v = 16'd1008 + 16'(code - 8'd112);
      end
    endcase
    return v;
  endfunction

  // update the key state for one accepted item and queue its result
  function void note_item(logic [2:0] act, logic [7:0] code, logic [15:0] ch,
                          logic [6:0] idx);
    key_result_t r;
    r.tkey   = '0;
    r.polled = POLL_EMPTY;
    r.held   = 1'b0;
    case (act)
      ACT_PRESS, ACT_RELEASE: begin
        r.tkey = translate_key(code, ch);
        if (r.tkey != 16'd0 && r.tkey < HELD_KEY_SLOTS)
          held_map[r.tkey[6:0]] = (act == ACT_PRESS);
        if (act == ACT_PRESS && r.tkey > QUEUE_MIN_EXCL) begin
          ring[wr_ptr] = r.tkey;
          wr_ptr++;
        end
      end
      ACT_POLL: begin
        if (rd_ptr != wr_ptr) begin
          r.polled = {1'b0, ring[rd_ptr]};
          rd_ptr++;
        end
      end
      ACT_QUERY: r.held = held_map[idx];
      ACT_FLUSH: rd_ptr = wr_ptr;
      default: ;
    endcase
    expected_q.push_back(r);
  endfunction

  function void report(string field, logic [16:0] exp_v, logic [16:0] act_v);
    $error("%s: expected %0h, got %0h", field, exp_v, act_v);
    mismatches++;
  endfunction

  function void check_result(logic [15:0] tkey, logic [16:0] polled, logic held);
    key_result_t e;
    if (expected_q.size() == 0) begin
      report("unexpected item translated_key", '0, {1'b0, tkey});
      return;
    end
    e = expected_q.pop_front();
    if (tkey !== e.tkey) report("translated_key", {1'b0, e.tkey}, {1'b0, tkey});
    if (polled !== e.polled) report("polled_key", e.polled, polled);
    if (held !== e.held) report("held", {16'd0, e.held}, {16'd0, held});
  endfunction
endclass

module tb_key_event_translate_queue_core;
  localparam int CLK_HALF         = 4;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int NAMED_KEY_COUNT  = 28;
  localparam logic [7:0] NAMED_KEYS [NAMED_KEY_COUNT] = '{
    8'd37, 8'd39, 8'd38, 8'd40, 8'd17, 8'd16, 8'd18, 8'd8, 8'd127, 8'd9,
    8'd10, 8'd13, 8'd36, 8'd35, 8'd33, 8'd34, 8'd112, 8'd113, 8'd114,
    8'd115, 8'd116, 8'd117, 8'd118, 8'd119, 8'd120, 8'd121, 8'd122, 8'd123
  };

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               cfg_wr_en     = 1'b0;
  logic               cfg_wr_data   = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic [2:0]         in_action     = ACT_PRESS;
  logic [7:0]         in_key_code   = '0;
  logic [15:0]        in_char_code  = '0;
  logic [6:0]         in_key_index  = '0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic [15:0]        out_translated_key;
  logic signed [16:0] out_polled_key;
  logic               out_held;

  bit tx_gaps      = 1'b1;
  bit rx_stalls    = 1'b1;
  bit rx_long_hold = 1'b0;

  key_scoreboard sb;

  key_event_translate_queue_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_key_code        (in_key_code),
    .in_char_code       (in_char_code),
    .in_key_index       (in_key_index),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_translated_key (out_translated_key),
    .out_polled_key     (out_polled_key),
    .out_held           (out_held)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_translated_key, out_polled_key, out_held);
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int n;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (rx_long_hold) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        rx_long_hold = 1'b0;
      end
      if (rx_stalls && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 8);
        out_ready = 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic send_item(input logic [2:0] act, input logic [7:0] code,
                           input logic [15:0] ch, input logic [6:0] idx);
    int gap;
    @(negedge clk);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_action    = act;
    in_key_code  = code;
    in_char_code = ch;
    in_key_index = idx;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_item(act, code, ch, idx);
  endtask

  task automatic stop_input();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic v);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.fkey_map_en = v;
  endtask

  task automatic send_random_item();
    logic [2:0]  act;
    logic [7:0]  code;
    logic [15:0] ch;
    logic [6:0]  idx;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 35)      act = ACT_PRESS;
    else if (pick < 55) act = ACT_RELEASE;
    else if (pick < 78) act = ACT_POLL;
    else if (pick < 94) act = ACT_QUERY;
    else if (pick < 97) act = ACT_FLUSH;
    else                act = ACT_FLUSH + 3'($urandom_range(1, 3));
    if ($urandom_range(0, 9) < 4) code = NAMED_KEYS[$urandom_range(0, NAMED_KEY_COUNT - 1)];
    else                          code = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0:       ch = 16'($urandom_range(0, 29));
      1:       ch = 16'($urandom_range(30, 127));
      2:       ch = 16'($urandom_range(128, 1023));
      default: ch = 16'($urandom_range(0, 65535));
    endcase
    if ($urandom_range(0, 1) == 0) idx = 7'($urandom_range(0, 15));
    else                           idx = 7'($urandom_range(0, 127));
    send_item(act, code, ch, idx);
  endtask

  initial begin
    sb = new;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    write_cfg(1'b0);

    // directed, function key map off
    send_item(ACT_POLL,    8'd0,   16'd0,     7'd0);   // empty ring
    send_item(ACT_PRESS,   8'd37,  16'd0,     7'd0);   // arrow: held, not queued
    send_item(ACT_QUERY,   8'd0,   16'd0,     7'd1);
    send_item(ACT_PRESS,   8'd0,   16'hFFFF,  7'd0);
    send_item(ACT_PRESS,   8'hFF,  16'd29,    7'd0);   // char below 30 -> 0
    send_item(ACT_PRESS,   8'd200, 16'd30,    7'd0);
    send_item(ACT_PRESS,   8'd112, 16'd65,    7'd0);   // F1 with map off
    send_item(ACT_PRESS,   8'd127, 16'd0,     7'd0);
    send_item(ACT_PRESS,   8'd0,   16'd127,   7'd0);   // top held bit
    send_item(ACT_QUERY,   8'd0,   16'd0,     7'd127);
    send_item(ACT_PRESS,   8'd0,   16'd128,   7'd0);   // past held bitmap
    send_item(ACT_PRESS,   8'd36,  16'd0,     7'd0);
    send_item(ACT_RELEASE, 8'd37,  16'd0,     7'd0);
    send_item(ACT_QUERY,   8'hFF,  16'hFFFF,  7'd1);
    send_item(ACT_QUERY,   8'd0,   16'd0,     7'd0);
    send_item(ACT_POLL,    8'd0,   16'd0,     7'd0);
    send_item(ACT_POLL,    8'd0,   16'd0,     7'd0);
    send_item(ACT_FLUSH,   8'd0,   16'd0,     7'd0);
    send_item(ACT_POLL,    8'd0,   16'd0,     7'd0);
    send_item(ACT_FLUSH + 3'd1, 8'hFF, 16'hFFFF, 7'h7F);  // unused actions
    send_item(ACT_FLUSH + 3'd2, 8'hFF, 16'hFFFF, 7'h7F);
    send_item(ACT_FLUSH + 3'd3, 8'hFF, 16'hFFFF, 7'h7F);
    stop_input();
    wait_idle();

    // directed, function key map on
    write_cfg(1'b1);
    send_item(ACT_PRESS,   8'd112, 16'd0,  7'd0);
    send_item(ACT_PRESS,   8'd123, 16'd0,  7'd0);
    send_item(ACT_PRESS,   8'd111, 16'd40, 7'd0);
    send_item(ACT_PRESS,   8'd124, 16'd50, 7'd0);
    send_item(ACT_POLL,    8'd0,   16'd0,  7'd0);

    // overrun: a full ring of unread pushes looks empty
    send_item(ACT_FLUSH, 8'd0, 16'd0, 7'd0);
    repeat (RING_SLOTS) send_item(ACT_PRESS, 8'd0, 16'($urandom_range(30, 65535)), 7'd0);
    send_item(ACT_POLL, 8'd0, 16'd0, 7'd0);
    send_item(ACT_PRESS, 8'd0, 16'($urandom_range(30, 65535)), 7'd0);
    send_item(ACT_POLL, 8'd0, 16'd0, 7'd0);
    send_item(ACT_POLL, 8'd0, 16'd0, 7'd0);

    repeat (600) send_random_item();

    // receiver holds off while items keep coming; block must back up
    tx_gaps      = 1'b0;
    rx_long_hold = 1'b1;
    repeat (40) send_random_item();
    tx_gaps = 1'b1;
    stop_input();
    wait_idle();

    write_cfg(1'b0);
    repeat (600) send_random_item();
    stop_input();
    wait_idle();

    // closing stretch at full rate
    write_cfg(1'b1);
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    repeat (300) send_random_item();
    stop_input();
    wait_idle();
    repeat (10) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_key_event_translate_queue_core: clean");
    end else begin
      $display("tb_key_event_translate_queue_core: errors");
    end
    $finish;
  end

  initial begin
    #(2 * CLK_HALF * 200000);
    $display("tb_key_event_translate_queue_core: errors");
    $finish;
  end

endmodule
